// ===== rtl/core/luhn_pkg.sv =====
package luhn_pkg;

	// Binary input and its decimal form. 2^54 stays below 10^17, so seventeen
	// BCD digits always hold the converted number.
	localparam int NUM_W      = 54;
	localparam int BCD_DIGITS = 17;
	localparam int BCD_W      = BCD_DIGITS * 4;

	// Shift-and-add-3 conversion: six bit steps per pipeline stage.
	localparam int STEPS_PER_STAGE = 6;
	localparam int DABBLE_STAGES   = NUM_W / STEPS_PER_STAGE;

	localparam int COUNT_W    = 5;
	localparam int HALF_SUM_W = 7;
	localparam int SUM_W      = 8;
	localparam int SUM_MAX    = 153;

	localparam int MAX_DIGITS_DEFAULT = 16;

	localparam logic [1:0] CLASS_INVALID    = 2'd0;
	localparam logic [1:0] CLASS_AMEX       = 2'd1;
	localparam logic [1:0] CLASS_MASTERCARD = 2'd2;
	localparam logic [1:0] CLASS_VISA       = 2'd3;

	// Lengths and leading digits of the card families.
	localparam int AMEX_LEN       = 15;
	localparam int MC_LEN         = 16;
	localparam int VISA_SHORT_LEN = 13;
	localparam int VISA_LONG_LEN  = 16;

	localparam logic [3:0] AMEX_LEAD     = 4'd3;
	localparam logic [3:0] AMEX_SECOND_A = 4'd4;
	localparam logic [3:0] AMEX_SECOND_B = 4'd7;
	localparam logic [3:0] MC_LEAD       = 4'd5;
	localparam logic [3:0] MC_SECOND_MIN = 4'd1;
	localparam logic [3:0] MC_SECOND_MAX = 4'd5;
	localparam logic [3:0] VISA_LEAD     = 4'd4;

	typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic [HALF_SUM_W-1:0] even_sum;
		logic [HALF_SUM_W-1:0] odd_sum;
		logic [COUNT_W-1:0]    count;
		logic                  amex;
		logic                  master;
		logic                  visa;
	} luhn_sum_t;

	// Doubles a decimal digit and adds the two digits of the product.
	function automatic logic [3:0] luhn_double(input logic [3:0] d);
		logic [4:0] dbl;
		dbl = {d, 1'b0};
		return (dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0];
	endfunction

endpackage

// ===== rtl/core/card_number_luhn_classifier.sv =====
// Card number classifier with the Luhn mod-10 check.
// The card channel carries one binary card number per transaction
// (card_valid / card_stall); the result channel returns card_class,
// checksum_ok and digit_count for it (result_valid / result_stall).
// Every card transaction gives exactly one result transaction, in order.
// Nine conversion stages turn the 54-bit card number into seventeen BCD
// digits, six shift-and-add-3 steps per stage, then one stage forms the two
// Luhn half sums, the digit count and the prefix tests, and the last stage
// completes the check and registers the result.
// Throughput is one transaction per cycle while card_stall stays low, set by
// the one-card-per-stage conversion chain.
// When result_stall is high, the result holds and the stages behind it keep
// filling any empty slots; card_stall rises only once all eleven stages hold
// a transaction and the result is still stalled.
// Reset clears every stage valid bit, so the pipeline starts empty and
// result_valid is low.
module card_number_luhn_classifier
	import luhn_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               card_valid,
	output logic               card_stall,
	input  logic [NUM_W-1:0]   card_number,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         card_class,
	output logic               checksum_ok,
	output logic [COUNT_W-1:0] digit_count
);

	localparam int NUM_STAGES = DABBLE_STAGES + 2;

	// Entry zero of each chain array is the card port itself.
	bcd_t             chain_bcd   [DABBLE_STAGES+1];
	logic [NUM_W-1:0] chain_bin   [DABBLE_STAGES+1];
	logic [DABBLE_STAGES:0] chain_valid;

	logic [NUM_STAGES-1:0] stage_valid;
	logic [NUM_STAGES-1:0] stage_load;

	logic      sum_valid;
	luhn_sum_t sum;

	assign chain_bcd[0]   = '0;
	assign chain_bin[0]   = card_number;
	assign chain_valid[0] = card_valid;

	// A stage takes a new transaction, or a bubble, whenever it is empty or the
	// stage after it moves on as well. This lets bubbles collapse under a stall.
	always_comb begin
		stage_valid = {result_valid, sum_valid, chain_valid[DABBLE_STAGES:1]};
		stage_load[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || !result_stall;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			stage_load[i] = !stage_valid[i] || stage_load[i+1];
		end
	end

	assign card_stall = !stage_load[0];

	for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
		luhn_dabble_stage u_dabble (
			.clk        (clk),
			.arst_n     (arst_n),
			.load       (stage_load[g]),
			.prev_valid (chain_valid[g]),
			.prev_bcd   (chain_bcd[g]),
			.prev_bin   (chain_bin[g]),
			.valid      (chain_valid[g+1]),
			.bcd        (chain_bcd[g+1]),
			.bin        (chain_bin[g+1])
		);
	end

	// The remaining binary bits of the last conversion stage are all shifted
	// out by then and are not needed past it.
	luhn_sum_stage u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (stage_load[DABBLE_STAGES]),
		.prev_valid (chain_valid[DABBLE_STAGES]),
		.prev_bcd   (chain_bcd[DABBLE_STAGES]),
		.valid      (sum_valid),
		.sum        (sum)
	);

	luhn_class_stage #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_class (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (stage_load[NUM_STAGES-1]),
		.prev_valid  (sum_valid),
		.prev_sum    (sum),
		.valid       (result_valid),
		.card_class  (card_class),
		.checksum_ok (checksum_ok),
		.digit_count (digit_count)
	);

`ifndef SYNTHESIS
	// Back pressure reaches the card side only with a full pipeline.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		card_stall |-> ((&stage_valid) && result_stall))
		else $error("card_stall raised while a pipeline slot is free");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((digit_count != '0) &&
			(digit_count <= COUNT_W'(MAX_DIGITS + 1))))
		else $error("digit_count out of range");

	a_class_needs_check: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (card_class != CLASS_INVALID)) |-> checksum_ok)
		else $error("card classified without a passing checksum");

	a_amex_length: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (card_class == CLASS_AMEX)) |->
			(digit_count == COUNT_W'(AMEX_LEN)))
		else $error("AMEX class with the wrong digit count");
`endif

endmodule

// ===== rtl/core/luhn_dabble_stage.sv =====
module luhn_dabble_stage
	import luhn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             prev_valid,
	input  bcd_t             prev_bcd,
	input  logic [NUM_W-1:0] prev_bin,
	output logic             valid,
	output bcd_t             bcd,
	output logic [NUM_W-1:0] bin
);

	logic             valid_s1;
	bcd_t             bcd_s1;
	logic [NUM_W-1:0] bin_s1;
	bcd_t             bcd_n;
	logic [NUM_W-1:0] bin_n;
	logic [BCD_W:0]   shifted;

	// Each step adjusts every digit of five or more, then shifts one binary bit in.
	always_comb begin
		bcd_n   = prev_bcd;
		bin_n   = prev_bin;
		shifted = '0;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (bcd_n[d] >= 4'd5) begin
					bcd_n[d] = bcd_n[d] + 4'd3;
				end
			end
			shifted = {bcd_n, bin_n[NUM_W-1]};
			bcd_n   = shifted[BCD_W-1:0];
			bin_n   = {bin_n[NUM_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && prev_valid) begin
			bcd_s1 <= bcd_n;
			bin_s1 <= bin_n;
		end
	end

	assign valid = valid_s1;
	assign bcd   = bcd_s1;
	assign bin   = bin_s1;

endmodule

// ===== rtl/core/luhn_sum_stage.sv =====
module luhn_sum_stage
	import luhn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  logic      prev_valid,
	input  bcd_t      prev_bcd,
	output logic      valid,
	output luhn_sum_t sum
);

	logic      valid_s2;
	luhn_sum_t sum_s2;
	luhn_sum_t sum_n;

	always_comb begin
		sum_n = '0;
		sum_n.count = COUNT_W'(1);
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (d % 2 == 0) begin
				sum_n.even_sum = sum_n.even_sum + HALF_SUM_W'(prev_bcd[d]);
			end else begin
				sum_n.odd_sum = sum_n.odd_sum + HALF_SUM_W'(luhn_double(prev_bcd[d]));
			end
			if (d > 0 && prev_bcd[d] != 4'd0) begin
				sum_n.count = COUNT_W'(d + 1);
			end
		end

		// Prefix tests look at fixed digit places for each family length.
		sum_n.amex = (sum_n.count == COUNT_W'(AMEX_LEN)) &&
			(prev_bcd[AMEX_LEN-1] == AMEX_LEAD) &&
			((prev_bcd[AMEX_LEN-2] == AMEX_SECOND_A) ||
			 (prev_bcd[AMEX_LEN-2] == AMEX_SECOND_B));
		sum_n.master = (sum_n.count == COUNT_W'(MC_LEN)) &&
			(prev_bcd[MC_LEN-1] == MC_LEAD) &&
			(prev_bcd[MC_LEN-2] >= MC_SECOND_MIN) &&
			(prev_bcd[MC_LEN-2] <= MC_SECOND_MAX);
		sum_n.visa = ((sum_n.count == COUNT_W'(VISA_SHORT_LEN)) &&
			 (prev_bcd[VISA_SHORT_LEN-1] == VISA_LEAD)) ||
			((sum_n.count == COUNT_W'(VISA_LONG_LEN)) &&
			 (prev_bcd[VISA_LONG_LEN-1] == VISA_LEAD));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && prev_valid) begin
			sum_s2 <= sum_n;
		end
	end

	assign valid = valid_s2;
	assign sum   = sum_s2;

endmodule

// ===== rtl/core/luhn_class_stage.sv =====
module luhn_class_stage
	import luhn_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               prev_valid,
	input  luhn_sum_t          prev_sum,
	output logic               valid,
	output logic [1:0]         card_class,
	output logic               checksum_ok,
	output logic [COUNT_W-1:0] digit_count
);

	localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_DIGITS + 1);

	logic               valid_s3;
	logic [1:0]         class_s3;
	logic               ok_s3;
	logic [COUNT_W-1:0] count_s3;
	logic [SUM_W-1:0]   total;
	logic               ok_n;
	logic [1:0]         class_n;
	logic [COUNT_W-1:0] count_n;

	always_comb begin
		total = SUM_W'(prev_sum.even_sum) + SUM_W'(prev_sum.odd_sum);
		// The sum never passes SUM_MAX, so a match against each multiple of ten
		// below it stands in for the remainder.
		ok_n = 1'b0;
		for (int k = 0; k * 10 <= SUM_MAX; k++) begin
			if (total == SUM_W'(k * 10)) begin
				ok_n = 1'b1;
			end
		end

		class_n = CLASS_INVALID;
		if (ok_n && prev_sum.count <= COUNT_W'(MAX_DIGITS)) begin
			if (prev_sum.amex) begin
				class_n = CLASS_AMEX;
			end else if (prev_sum.master) begin
				class_n = CLASS_MASTERCARD;
			end else if (prev_sum.visa) begin
				class_n = CLASS_VISA;
			end
		end

		count_n = (prev_sum.count > COUNT_SAT) ? COUNT_SAT : prev_sum.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load) begin
			valid_s3 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && prev_valid) begin
			class_s3 <= class_n;
			ok_s3    <= ok_n;
			count_s3 <= count_n;
		end
	end

	assign valid       = valid_s3;
	assign card_class  = class_s3;
	assign checksum_ok = ok_s3;
	assign digit_count = count_s3;

endmodule
